// ===== sv/gbss_pkg.sv =====
// Shared types and constants for the gap buffer sequence store.
package gbss_pkg;

    localparam int CAPACITY    = 1024;
    localparam int ENTRY_WIDTH = 32;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = ADDR_W + 1;

    localparam int FUNC_W   = 2;
    localparam int POS_W    = 11;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Compare width wide enough for both positions and counts
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   end_position;
        logic [VALUE_W-1:0] entry_value;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  read_value;
        logic [POS_W-1:0]    entry_count;
    } t_out;

    typedef struct packed {
        logic take;
        logic check;
        logic cap_read;
        logic move;
        logic edit;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic is_read;
        logic at_pos;
        logic wr_pend;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/gbss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/gbss_ctrl.sv =====
// Controller state machine: check, read capture or gap move and edit, result.
module gbss_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  gbss_pkg::t_stat i_stat,
    output gbss_pkg::t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_CHECK = 6'b000010,
        S_READ  = 6'b000100,
        S_MOVE  = 6'b001000,
        S_EDIT  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.err) begin
                    n_state = S_DONE;
                end else if (i_stat.is_read) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_READ: begin
                o_cmd.cap_read = 1'b1;
                n_state        = S_DONE;
            end
            S_MOVE: begin
                o_cmd.move = 1'b1;
                // wait for the last copy to land before editing
                if (i_stat.at_pos && !i_stat.wr_pend) begin
                    n_state = S_EDIT;
                end
            end
            S_EDIT: begin
                o_cmd.edit = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// ===== sv/gbss_dp.sv =====
// Datapath: item latch, gap pointers, entry store, copy pipeline and result register.
module gbss_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gbss_pkg::t_in   i_in,
    input  gbss_pkg::t_cmd  i_cmd,
    output gbss_pkg::t_stat o_stat,
    input  logic            i_out_stall,
    output logic            o_out_valid,
    output gbss_pkg::t_out  o_out
);

    gbss_pkg::t_in  r_item;
    gbss_pkg::t_out r_out;
    logic           r_out_valid;

    logic [gbss_pkg::CNT_W-1:0]  r_gs, n_gs;
    logic [gbss_pkg::CNT_W-1:0]  r_ge, n_ge;
    logic [gbss_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                        r_wr_pend, n_wr_pend;
    logic [gbss_pkg::ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic [gbss_pkg::STATUS_W-1:0]   r_status;
    logic [gbss_pkg::ENTRY_WIDTH-1:0] r_rd_value;

    logic [gbss_pkg::CMP_W-1:0] pos_x, end_x, gs_x, ge_x, cnt_x, slot_x;
    logic [gbss_pkg::CNT_W-1:0] del_n;
    logic bad, full, step_left, step_right, out_free;

    logic                             ram_wr_en, ram_rd_en;
    logic [gbss_pkg::ADDR_W-1:0]      ram_wr_addr, ram_rd_addr;
    logic [gbss_pkg::ENTRY_WIDTH-1:0] ram_wr_data, ram_rd_data;

    assign pos_x = gbss_pkg::CMP_W'(r_item.position);
    assign end_x = gbss_pkg::CMP_W'(r_item.end_position);
    assign gs_x  = gbss_pkg::CMP_W'(r_gs);
    assign ge_x  = gbss_pkg::CMP_W'(r_ge);
    assign cnt_x = gbss_pkg::CMP_W'(r_cnt);
    assign del_n = gbss_pkg::CNT_W'(end_x - pos_x);

    // Logical index to physical slot: skip over the gap
    assign slot_x = (pos_x < gs_x) ? pos_x : (ge_x + (pos_x - gs_x));

    always_comb begin
        bad  = 1'b0;
        full = 1'b0;
        case (r_item.func)
            gbss_pkg::FUNC_INSERT: begin
                bad  = (pos_x > cnt_x);
                full = !bad && (cnt_x >= gbss_pkg::CMP_W'(gbss_pkg::CAPACITY));
            end
            gbss_pkg::FUNC_DELETE: begin
                bad = (pos_x > end_x) || (end_x > cnt_x);
            end
            gbss_pkg::FUNC_READ: begin
                bad = (pos_x >= cnt_x);
            end
            default: begin
                bad = 1'b1;
            end
        endcase
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step_left  = i_cmd.move && (gs_x > pos_x);
    assign step_right = i_cmd.move && (gs_x < pos_x);

    assign o_stat.err      = bad || full;
    assign o_stat.is_read  = (r_item.func == gbss_pkg::FUNC_READ);
    assign o_stat.at_pos   = (gs_x == pos_x);
    assign o_stat.wr_pend  = r_wr_pend;
    assign o_stat.out_free = out_free;

    always_comb begin
        n_gs        = r_gs;
        n_ge        = r_ge;
        n_cnt       = r_cnt;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        ram_rd_en   = 1'b0;
        ram_rd_addr = slot_x[gbss_pkg::ADDR_W-1:0];
        ram_wr_en   = r_wr_pend;
        ram_wr_addr = r_wr_addr;
        ram_wr_data = ram_rd_data;
        if (i_cmd.check) begin
            ram_rd_en = 1'b1;
        end
        if (step_left) begin
            // copy the entry just before the gap to the top end of the gap
            ram_rd_en   = 1'b1;
            ram_rd_addr = gbss_pkg::ADDR_W'(r_gs - 1'b1);
            n_gs        = r_gs - 1'b1;
            n_ge        = r_ge - 1'b1;
            n_wr_pend   = 1'b1;
            n_wr_addr   = gbss_pkg::ADDR_W'(r_ge - 1'b1);
        end else if (step_right) begin
            // copy the entry just after the gap to its bottom end
            ram_rd_en   = 1'b1;
            ram_rd_addr = r_ge[gbss_pkg::ADDR_W-1:0];
            n_gs        = r_gs + 1'b1;
            n_ge        = r_ge + 1'b1;
            n_wr_pend   = 1'b1;
            n_wr_addr   = r_gs[gbss_pkg::ADDR_W-1:0];
        end
        if (i_cmd.edit) begin
            if (r_item.func == gbss_pkg::FUNC_INSERT) begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_gs[gbss_pkg::ADDR_W-1:0];
                ram_wr_data = gbss_pkg::ENTRY_WIDTH'(r_item.entry_value);
                n_gs        = r_gs + 1'b1;
                n_cnt       = r_cnt + 1'b1;
            end else begin
                n_ge  = r_ge + del_n;
                n_cnt = r_cnt - del_n;
            end
        end
    end

    gbss_ram #(
        .WIDTH (gbss_pkg::ENTRY_WIDTH),
        .DEPTH (gbss_pkg::CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs        <= '0;
            r_ge        <= gbss_pkg::CNT_W'(gbss_pkg::CAPACITY);
            r_cnt       <= '0;
            r_wr_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_gs      <= n_gs;
            r_ge      <= n_ge;
            r_cnt     <= n_cnt;
            r_wr_pend <= n_wr_pend;
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= n_wr_addr;
        if (i_cmd.take) begin
            r_item <= i_in;
        end
        if (i_cmd.check) begin
            r_status   <= bad ? gbss_pkg::ST_BAD : (full ? gbss_pkg::ST_FULL : gbss_pkg::ST_OK);
            r_rd_value <= '0;
        end
        if (i_cmd.cap_read) begin
            r_rd_value <= ram_rd_data;
        end
        if (i_cmd.finish) begin
            r_out.status      <= r_status;
            r_out.read_value  <= gbss_pkg::VALUE_W'(r_rd_value);
            r_out.entry_count <= gbss_pkg::POS_W'(r_cnt);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_gap_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        gbss_pkg::CNT_W'(r_ge - r_gs) == gbss_pkg::CNT_W'(gbss_pkg::CAPACITY) - r_cnt)
        else $error("gap length does not match entry count");

    a_gap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gs <= r_ge)
        else $error("gap start passed gap end");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= gbss_pkg::CNT_W'(gbss_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_edit_no_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.edit |-> !r_wr_pend)
        else $error("edit overlaps a pending gap copy");

    a_copy_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step_left || step_right) |=> r_wr_pend)
        else $error("gap step without its copy write");

endmodule

// ===== sv/gap_buffer_sequence_store_unit.sv =====
// Gap buffer sequence store: keeps up to CAPACITY entries as a gap buffer in one
// RAM. One item is in work at a time. An error item goes from the check straight
// to the result; a read captures its entry in between. An insert or delete first
// moves the gap to the edit point, copying one entry per cycle through the RAM's
// single read and single write port, until the gap start reaches the requested
// position, and then edits. The finished result sits in an output register, so
// the next item is accepted while it waits.
module gap_buffer_sequence_store_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  gbss_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output gbss_pkg::t_out o_out
);

    gbss_pkg::t_cmd  cmd;
    gbss_pkg::t_stat stat;

    gbss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    gbss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_out       (o_out)
    );

endmodule
